// ===== rtl/shc_pkg.sv =====
package shc_pkg;

    localparam int NAX      = 3;   // x, y, z
    localparam int FORCE_W  = 32;
    localparam int ENERGY_W = 48;
    localparam int CFG_W    = 32;
    localparam int RADIUS_W = 31;
    localparam int MAG_W    = 33;  // |p - origin|
    localparam int SQ_W     = 66;  // sum of three squared magnitudes
    localparam int ROOT_W   = 34;  // floor(sqrt) of SQ_W bits, padded to an even split
    localparam int E_CAP_SH = 48;  // energy increment cap is 2^48
    localparam int M_CAP_SH = 33;  // force increment cap is 2^33
    localparam int MUL_NCH  = 2;   // partial-product stages in the wide multipliers
    localparam int ADDR_W   = 5;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_SPRING   = 3'd4
    } t_reg_idx;

    typedef logic [NAX-1:0][MAG_W-1:0] t_mag3;

endpackage

// ===== rtl/shc_mul.sv =====
module shc_mul #(
    parameter int AW  = 60,
    parameter int BW  = 32,
    parameter int NCH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int CW = (AW + NCH - 1) / NCH;
    localparam int AP = CW * NCH;
    localparam int PW = AW + BW;

    logic [AP-1:0] w_a_pad;
    logic [PW-1:0] r_acc [NCH];

    assign w_a_pad = AP'(i_a);

    // One chunk of a times b per stage, accumulated into the running sum.
    for (genvar j = 0; j < NCH; j++) begin : g_stage
        logic [AP-1:0]    a_in;
        logic [BW-1:0]    b_in;
        logic [CW+BW-1:0] pp;
        logic [PW-1:0]    n_acc;

        if (j == 0) begin : g_first
            assign a_in = w_a_pad;
            assign b_in = i_b;
        end else begin : g_next
            logic [AP-1:0] r_a;
            logic [BW-1:0] r_b;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a <= g_stage[j-1].a_in;
                    r_b <= g_stage[j-1].b_in;
                end
            end
            assign a_in = r_a;
            assign b_in = r_b;
        end

        assign pp = a_in[j*CW +: CW] * b_in;

        if (j == 0) begin : g_acc0
            assign n_acc = PW'(pp);
        end else begin : g_accn
            assign n_acc = r_acc[j-1] + (PW'(pp) << (j * CW));
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[j] <= n_acc;
            end
        end
    end

    assign o_p = r_acc[NCH-1];

endmodule

// ===== rtl/shc_sqrt.sv =====
module shc_sqrt
    import shc_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_radicand,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SW-1:0]     o_side
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              r_valid [ROOT_W];
    logic [ROOT_W-1:0] r_root  [ROOT_W];
    logic [SW-1:0]     r_side  [ROOT_W];

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [X_W-1:0]    x_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic              v_in;
        logic [SW-1:0]     side_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign x_in    = X_W'(i_radicand);
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign x_in    = g_stage[k-1].g_carry.r_x;
            assign rem_in  = g_stage[k-1].g_carry.r_rem;
            assign root_in = r_root[k-1];
            assign v_in    = r_valid[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], x_in[2*B+1 -: 2]};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            logic [X_W-1:0]   r_x;
            logic [REM_W-1:0] r_rem;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x   <= x_in;
                    r_rem <= n_rem;
                end
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// ===== rtl/shc_div.sv =====
module shc_div
    import shc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  t_mag3                            i_mag,
    input  logic [ROOT_W-1:0]                i_den,
    input  logic [SW-1:0]                    i_side,
    output logic                             o_valid,
    output logic [NAX-1:0][FRAC_BITS:0]      o_quo,
    output logic [SW-1:0]                    o_side
);

    // Quotient is mag * 2^F / den with mag <= den, so it needs F+1 bits and
    // the partial remainder can start from mag >> 1.
    localparam int QW  = FRAC_BITS + 1;
    localparam int NST = QW;

    logic                      r_valid [NST];
    logic [NAX-1:0][QW-1:0]    r_quo   [NST];
    logic [SW-1:0]             r_side  [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [NAX-1:0][ROOT_W-1:0] rem_in;
        logic [NAX-1:0]             bit_in;
        logic [NAX-1:0][QW-1:0]     quo_in;
        logic [ROOT_W-1:0]          den_in;
        logic                       v_in;
        logic [SW-1:0]              side_in;
        logic [NAX-1:0][ROOT_W-1:0] n_rem;
        logic [NAX-1:0][QW-1:0]     n_quo;
        logic [ROOT_W:0]            rem_sh;

        if (k == 0) begin : g_first
            always_comb begin
                for (int a = 0; a < NAX; a++) begin
                    rem_in[a] = ROOT_W'(i_mag[a][MAG_W-1:1]);
                    bit_in[a] = i_mag[a][0];
                end
            end
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign v_in    = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = g_stage[k-1].g_carry.r_rem;
            assign bit_in  = '0;
            assign quo_in  = r_quo[k-1];
            assign den_in  = g_stage[k-1].g_carry.r_den;
            assign v_in    = r_valid[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            rem_sh = '0;
            for (int a = 0; a < NAX; a++) begin
                rem_sh = {rem_in[a], bit_in[a]};
                if (rem_sh >= {1'b0, den_in}) begin
                    n_rem[a] = ROOT_W'(rem_sh - {1'b0, den_in});
                    n_quo[a] = {quo_in[a][QW-2:0], 1'b1};
                end else begin
                    n_rem[a] = rem_sh[ROOT_W-1:0];
                    n_quo[a] = {quo_in[a][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k]  <= n_quo;
                r_side[k] <= side_in;
            end
        end

        if (k < NST - 1) begin : g_carry
            logic [NAX-1:0][ROOT_W-1:0] r_rem;
            logic [ROOT_W-1:0]          r_den;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                    r_den <= den_in;
                end
            end
        end
    end

    assign o_valid = r_valid[NST-1];
    assign o_quo   = r_quo[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ===== rtl/sphere_harmonic_confinement_force.sv =====
// Harmonic spherical wall: takes one particle position with running force and
// energy sums and returns the sums with the wall's contribution added. A particle
// at distance d > radius from the configured origin gets 0.5*k*s*s added to the
// energy and -k*s*(p-origin)/d to each force component, with s = d - radius;
// all other particles pass their sums through unchanged with outside low. Force
// sums saturate to 32 bits, the energy sum to the top of 48 bits, and saturated
// flags any clip. It takes one item per clock unless a result waits on the output;
// the pipeline contains the 34-stage square root and the FRAC_BITS+1-stage divider
// that forms the unit vector. The whole pipeline holds while a result waits on
// the output, so a stall loses and repeats nothing.
// Write configuration registers only while no item is in flight.
module sphere_harmonic_confinement_force
    import shc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item input
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [FORCE_W-1:0]  i_pos_x,
    input  logic signed [FORCE_W-1:0]  i_pos_y,
    input  logic signed [FORCE_W-1:0]  i_pos_z,
    input  logic signed [FORCE_W-1:0]  i_force_in_x,
    input  logic signed [FORCE_W-1:0]  i_force_in_y,
    input  logic signed [FORCE_W-1:0]  i_force_in_z,
    input  logic signed [ENERGY_W-1:0] i_energy_in,
    // result output
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [FORCE_W-1:0]  o_force_out_x,
    output logic signed [FORCE_W-1:0]  o_force_out_y,
    output logic signed [FORCE_W-1:0]  o_force_out_z,
    output logic signed [ENERGY_W-1:0] o_energy_out,
    output logic                       o_outside,
    output logic                       o_saturated,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [CFG_W-1:0]           pwdata,
    output logic [CFG_W-1:0]           prdata,
    output logic                       pready
);

    localparam int F     = FRAC_BITS;
    localparam int S_W   = ROOT_W;            // overshoot s
    localparam int SQS_W = 2 * S_W;           // s*s
    localparam int Q_W   = SQS_W - F;         // q = s*s >> F
    localparam int KS_W  = CFG_W + S_W;       // k*s
    localparam int G_W   = KS_W - F;          // g = k*s >> F
    localparam int U_W   = F + 1;             // unit vector component
    localparam int KQ_W  = CFG_W + Q_W;
    localparam int GU_W  = G_W + U_W;
    localparam int E_W   = E_CAP_SH + 1;
    localparam int M_W   = M_CAP_SH + 1;
    localparam int ES_W  = ENERGY_W + 2;
    localparam int FS_W  = M_W + 2;

    localparam logic [KQ_W-1:0]     E_CAP   = KQ_W'(1) << E_CAP_SH;
    localparam logic [GU_W-F-1:0]   M_CAP   = (GU_W - F)'(1) << M_CAP_SH;
    localparam logic [RADIUS_W-1:0] ONE_FIX = RADIUS_W'(1) << F;

    typedef struct packed {
        t_mag3                           mag;
        logic [NAX-1:0]                  pos;
        logic [NAX-1:0][FORCE_W-1:0]     force_v;
        logic [ENERGY_W-1:0]             energy;
    } t_sq_side;

    typedef struct packed {
        logic                            outside;
        logic [NAX-1:0]                  pos;
        logic [NAX-1:0][FORCE_W-1:0]     force_v;
        logic [ENERGY_W-1:0]             energy;
        logic [Q_W-1:0]                  q;
        logic [G_W-1:0]                  g;
    } t_dv_side;

    typedef struct packed {
        logic                            outside;
        logic [NAX-1:0]                  pos;
        logic [NAX-1:0][FORCE_W-1:0]     force_v;
        logic [ENERGY_W-1:0]             energy;
    } t_md_side;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    r_origin [NAX];
    logic [RADIUS_W-1:0] r_radius;
    logic [CFG_W-1:0]    r_spring;
    t_reg_idx            w_reg_idx;
    logic                w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NAX; a++) begin
                r_origin[a] <= '0;
            end
            r_radius <= ONE_FIX;
            r_spring <= CFG_W'(ONE_FIX);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_ORIGIN_X: r_origin[0] <= pwdata;
                REG_ORIGIN_Y: r_origin[1] <= pwdata;
                REG_ORIGIN_Z: r_origin[2] <= pwdata;
                REG_RADIUS:   r_radius    <= pwdata[RADIUS_W-1:0];
                REG_SPRING:   r_spring    <= pwdata;
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_ORIGIN_X: prdata = r_origin[0];
            REG_ORIGIN_Y: prdata = r_origin[1];
            REG_ORIGIN_Z: prdata = r_origin[2];
            REG_RADIUS:   prdata = CFG_W'(r_radius);
            REG_SPRING:   prdata = r_spring;
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline enable: every stage advances together unless the output
    // register holds a result that has not been taken.
    // ------------------------------------------------------------------
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // ------------------------------------------------------------------
    // Stage 1: offset from the origin, its magnitude and its sign
    // ------------------------------------------------------------------
    logic [NAX-1:0][FORCE_W-1:0] w_pos_in;
    logic [NAX-1:0][FORCE_W-1:0] w_force_in;
    logic [NAX-1:0][MAG_W-1:0]   w_diff;
    t_mag3                       n_s1_mag;
    logic [NAX-1:0]              n_s1_pos;

    assign w_pos_in   = {i_pos_z, i_pos_y, i_pos_x};
    assign w_force_in = {i_force_in_z, i_force_in_y, i_force_in_x};

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            w_diff[a]   = {w_pos_in[a][FORCE_W-1], w_pos_in[a]}
                        - {r_origin[a][CFG_W-1], r_origin[a]};
            n_s1_mag[a] = w_diff[a][MAG_W-1] ? MAG_W'(-w_diff[a]) : w_diff[a];
            // a positive offset pushes the force negative
            n_s1_pos[a] = !w_diff[a][MAG_W-1] && (w_diff[a] != '0);
        end
    end

    logic     r_s1_valid;
    t_sq_side r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1.mag     <= n_s1_mag;
            r_s1.pos     <= n_s1_pos;
            r_s1.force_v <= w_force_in;
            r_s1.energy  <= i_energy_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the three magnitudes
    // ------------------------------------------------------------------
    logic                        r_s2_valid;
    logic [NAX-1:0][SQ_W-1:0]    r_s2_sq;
    t_sq_side                    r_s2;
    logic [NAX-1:0][SQ_W-1:0]    n_s2_sq;

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            n_s2_sq[a] = SQ_W'(r_s1.mag[a]) * SQ_W'(r_s1.mag[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sq <= n_s2_sq;
            r_s2    <= r_s1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared distance (below 3 * 2^64, so it fits SQ_W bits)
    // ------------------------------------------------------------------
    logic            r_s3_valid;
    logic [SQ_W-1:0] r_s3_sum;
    t_sq_side        r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_sum <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_s3     <= r_s2;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage
    // ------------------------------------------------------------------
    logic              w_sr_valid;
    logic [ROOT_W-1:0] w_sr_root;
    t_sq_side          w_sr_side;

    shc_sqrt #(
        .SW ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s3_valid),
        .i_radicand (r_s3_sum),
        .i_side     (r_s3),
        .o_valid    (w_sr_valid),
        .o_root     (w_sr_root),
        .o_side     (w_sr_side)
    );

    // ------------------------------------------------------------------
    // Stage 4: overshoot beyond the surface
    // ------------------------------------------------------------------
    logic              r_s4_valid;
    logic              r_s4_outside;
    logic [S_W-1:0]    r_s4_s;
    logic [ROOT_W-1:0] r_s4_den;
    t_sq_side          r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= w_sr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_outside <= w_sr_root > ROOT_W'(r_radius);
            r_s4_s       <= w_sr_root - ROOT_W'(r_radius);
            r_s4_den     <= w_sr_root;
            r_s4         <= w_sr_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: s*s for the energy, k*s for the force magnitude
    // ------------------------------------------------------------------
    logic              r_s5_valid;
    logic              r_s5_outside;
    logic [SQS_W-1:0]  r_s5_sqs;
    logic [KS_W-1:0]   r_s5_ks;
    logic [ROOT_W-1:0] r_s5_den;
    t_sq_side          r_s5;
    logic [SQS_W-1:0]  n_s5_sqs;
    logic [KS_W-1:0]   n_s5_ks;

    assign n_s5_sqs = SQS_W'(r_s4_s) * SQS_W'(r_s4_s);
    assign n_s5_ks  = KS_W'(r_spring) * KS_W'(r_s4_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_outside <= r_s4_outside;
            r_s5_sqs     <= n_s5_sqs;
            r_s5_ks      <= n_s5_ks;
            r_s5_den     <= r_s4_den;
            r_s5         <= r_s4;
        end
    end

    // ------------------------------------------------------------------
    // Unit vector: |offset| * 2^F / d on three lanes
    // ------------------------------------------------------------------
    t_dv_side                   w_dv_in;
    t_dv_side                   w_dv_side;
    logic                       w_dv_valid;
    logic [NAX-1:0][U_W-1:0]    w_dv_quo;

    assign w_dv_in.outside = r_s5_outside;
    assign w_dv_in.pos     = r_s5.pos;
    assign w_dv_in.force_v = r_s5.force_v;
    assign w_dv_in.energy  = r_s5.energy;
    assign w_dv_in.q       = r_s5_sqs[SQS_W-1:F];
    assign w_dv_in.g       = r_s5_ks[KS_W-1:F];

    shc_div #(
        .FRAC_BITS (FRAC_BITS),
        .SW        ($bits(t_dv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_valid),
        .i_mag   (r_s5.mag),
        .i_den   (r_s5_den),
        .i_side  (w_dv_in),
        .o_valid (w_dv_valid),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // ------------------------------------------------------------------
    // Wide products: k*q for the energy, g*u for each force component
    // ------------------------------------------------------------------
    logic [KQ_W-1:0]          w_kq;
    logic [NAX-1:0][GU_W-1:0] w_gu;

    shc_mul #(
        .AW  (Q_W),
        .BW  (CFG_W),
        .NCH (MUL_NCH)
    ) u_mul_kq (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_dv_side.q),
        .i_b   (r_spring),
        .o_p   (w_kq)
    );

    for (genvar a = 0; a < NAX; a++) begin : g_mul_gu
        shc_mul #(
            .AW  (G_W),
            .BW  (U_W),
            .NCH (MUL_NCH)
        ) u_mul_gu (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_dv_side.g),
            .i_b   (w_dv_quo[a]),
            .o_p   (w_gu[a])
        );
    end

    // Carry the sums alongside the multiplier stages.
    logic [MUL_NCH-1:0] r_md_valid;
    t_md_side           r_md_side [MUL_NCH];
    t_md_side           w_md_in;

    assign w_md_in.outside = w_dv_side.outside;
    assign w_md_in.pos     = w_dv_side.pos;
    assign w_md_in.force_v = w_dv_side.force_v;
    assign w_md_in.energy  = w_dv_side.energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md_valid <= '0;
        end else if (w_en) begin
            r_md_valid <= {r_md_valid[MUL_NCH-2:0], w_dv_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_md_side[0] <= w_md_in;
            for (int j = 1; j < MUL_NCH; j++) begin
                r_md_side[j] <= r_md_side[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: cap the increments, add them and saturate the sums
    // ------------------------------------------------------------------
    t_md_side                    w_fin;
    logic [KQ_W-1:0]             w_e_full;
    logic [E_W-1:0]              w_e;
    logic signed [ES_W-1:0]      w_esum;
    logic [NAX-1:0][GU_W-F-1:0]  w_m_full;
    logic [NAX-1:0][M_W-1:0]     w_m;
    logic [NAX-1:0][FS_W-1:0]    w_fsum;
    logic [NAX-1:0][FORCE_W-1:0] n_out_force;
    logic [ENERGY_W-1:0]         n_out_energy;
    logic                        n_out_sat;

    assign w_fin = r_md_side[MUL_NCH-1];

    always_comb begin
        n_out_sat = 1'b0;

        // energy grows by floor(k*q / 2^(F+1)), never negative
        w_e_full = w_kq >> (F + 1);
        w_e      = (w_e_full > E_CAP) ? E_CAP[E_W-1:0] : w_e_full[E_W-1:0];
        w_esum   = ES_W'(signed'(w_fin.energy)) + signed'(ES_W'(w_e));
        if (!w_fin.outside) begin
            n_out_energy = w_fin.energy;
        end else if (!w_esum[ES_W-1] && (w_esum[ES_W-2:ENERGY_W-1] != '0)) begin
            n_out_energy = {1'b0, {(ENERGY_W-1){1'b1}}};
            n_out_sat    = 1'b1;
        end else begin
            n_out_energy = w_esum[ENERGY_W-1:0];
        end

        // force moves toward the origin by floor(g*u / 2^F)
        for (int a = 0; a < NAX; a++) begin
            w_m_full[a] = (GU_W - F)'(w_gu[a] >> F);
            w_m[a]      = (w_m_full[a] > M_CAP) ? M_CAP[M_W-1:0] : w_m_full[a][M_W-1:0];
            w_fsum[a]   = w_fin.pos[a]
                        ? FS_W'(signed'(w_fin.force_v[a])) - FS_W'(w_m[a])
                        : FS_W'(signed'(w_fin.force_v[a])) + FS_W'(w_m[a]);
            if (!w_fin.outside) begin
                n_out_force[a] = w_fin.force_v[a];
            end else if (w_fsum[a][FS_W-1:FORCE_W-1] != '0
                      && w_fsum[a][FS_W-1:FORCE_W-1] != '1) begin
                n_out_force[a] = w_fsum[a][FS_W-1] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                                   : {1'b0, {(FORCE_W-1){1'b1}}};
                n_out_sat      = 1'b1;
            end else begin
                n_out_force[a] = w_fsum[a][FORCE_W-1:0];
            end
        end
    end

    logic                        r_out_valid;
    logic [NAX-1:0][FORCE_W-1:0] r_out_force;
    logic [ENERGY_W-1:0]         r_out_energy;
    logic                        r_out_outside;
    logic                        r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_md_valid[MUL_NCH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_force   <= n_out_force;
            r_out_energy  <= n_out_energy;
            r_out_outside <= w_fin.outside;
            r_out_sat     <= n_out_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_force_out_x = signed'(r_out_force[0]);
    assign o_force_out_y = signed'(r_out_force[1]);
    assign o_force_out_z = signed'(r_out_force[2]);
    assign o_energy_out  = signed'(r_out_energy);
    assign o_outside     = r_out_outside;
    assign o_saturated   = r_out_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a particle inside the sphere never clips anything
    a_inside_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_outside |-> !o_saturated)
        else $error("saturation reported for a particle inside the sphere");

    // an outside particle has a nonzero overshoot no larger than its distance
    a_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid && r_s4_outside |-> (r_s4_s != '0) && (r_s4_s <= r_s4_den))
        else $error("overshoot out of range");

    // a stall freezes the middle of the pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_s5_valid) && $stable(r_s5_sqs) && $stable(r_s5_den))
        else $error("pipeline moved during a stall");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
